/* hdl/trc_pkg.sv */
// ----------------------------------------------------------------------------
// trc_pkg
// Shared types and constants of the triangle rectangle cull and vertex
// reindex block: field widths, channel payloads and register indexes.
// ----------------------------------------------------------------------------
package trc_pkg;

    // Table and coordinate geometry.
    localparam int VERTEX_SPACE = 65536;
    localparam int IDX_W        = $clog2(VERTEX_SPACE);
    localparam int COORD_BITS   = 24;
    localparam int IN_IDX_W     = 16;
    localparam int NUM_W        = 16;
    localparam int CNT_W        = NUM_W + 1;
    localparam int DENSE_DEPTH  = 1 << NUM_W;

    // The compact counter saturates once every 16-bit number is handed out.
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(1) << NUM_W;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_X = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_MAX_X = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_MIN_Z = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_MAX_Z = CFG_IDX_W'(3);

    typedef logic signed [COORD_BITS-1:0] t_coord;

    // One triangle on the input channel.
    typedef struct packed {
        logic [IN_IDX_W-1:0] corner_index_a;
        logic [IN_IDX_W-1:0] corner_index_b;
        logic [IN_IDX_W-1:0] corner_index_c;
        t_coord              a_x;
        t_coord              a_y;
        t_coord              a_z;
        t_coord              b_x;
        t_coord              b_y;
        t_coord              b_z;
        t_coord              c_x;
        t_coord              c_y;
        t_coord              c_z;
    } t_tri;

    // One corner result on the output channel.
    typedef struct packed {
        logic [NUM_W-1:0] compact_index;
        logic             vertex_is_new;
        t_coord           out_x;
        t_coord           out_y;
        t_coord           out_z;
        logic             last_corner;
    } t_res;

    // Configuration write.
    typedef struct packed {
        logic [CFG_IDX_W-1:0] index;
        t_coord               value;
    } t_cfg;

    // Keep rectangle.
    typedef struct packed {
        t_coord min_x;
        t_coord max_x;
        t_coord min_z;
        t_coord max_z;
    } t_rect;

    // Sequencer to remap unit.
    typedef struct packed {
        logic                start;
        logic                clear;
        logic [IN_IDX_W-1:0] index;
    } t_rmp_req;

    // Remap unit to sequencer.
    typedef struct packed {
        logic             done;
        logic             is_new;
        logic [NUM_W-1:0] number;
    } t_rmp_rsp;

endpackage

/* hdl/trc_if.sv */
// ----------------------------------------------------------------------------
// trc_if
// Valid/ready channel interfaces for triangles, corner results and
// configuration writes.
// ----------------------------------------------------------------------------
interface trc_tri_if import trc_pkg::*; ();
    logic valid;
    logic ready;
    t_tri data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface trc_res_if import trc_pkg::*; ();
    logic valid;
    logic ready;
    t_res data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface trc_cfg_if import trc_pkg::*; ();
    logic valid;
    logic ready;
    t_cfg data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* hdl/triangle_rect_cull_vertex_reindex.sv */
// ----------------------------------------------------------------------------
// triangle_rect_cull_vertex_reindex
// Culls triangles against an x/z keep rectangle and renumbers the corner
// indices of kept triangles into a compact range, emitting new vertices.
// ----------------------------------------------------------------------------
// Operation: each corner in turn goes through the shared compare unit (check,
//   then wait for the registered verdict); a failing corner rejects the
//   triangle. A kept triangle then passes each corner through the remap unit
//   (sparse read, dense read, decide, emit). A new triangle is accepted only
//   once the previous one is finished; a stalled receiver holds the emit step.
//   The pace is set by the shared compare unit and the single-port remap
//   memories.
// Reset: synchronous active low; rectangle bounds go to zero, the table is
//   empty. No clearing pass is needed, since the table is tracked by a count.
// ----------------------------------------------------------------------------
module triangle_rect_cull_vertex_reindex import trc_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    trc_tri_if.sink   i_tri,
    trc_res_if.source o_res,
    trc_cfg_if.sink   i_cfg
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHK,
        S_CHKW,
        S_LOOK,
        S_LWAIT,
        S_EMIT
    } t_state;

    t_state   r_state;
    t_state   n_state;
    logic [1:0] r_k;
    logic [1:0] n_k;
    t_tri     r_item;
    t_tri     n_item;
    t_rect    r_rect;
    t_rect    n_rect;
    t_res     r_out;
    t_res     n_out;
    logic     r_out_valid;
    logic     n_out_valid;
    t_res     r_pend;
    t_res     n_pend;

    logic                cfg_wr;
    logic                cfg_hit;
    logic                pass;
    t_coord              cx;
    t_coord              cy;
    t_coord              cz;
    logic [IN_IDX_W-1:0] cidx;
    t_rmp_req            rmp_req;
    t_rmp_rsp            rmp_rsp;

    // Select the current corner.
    always_comb begin
        case (r_k)
            2'd0: begin
                cx = r_item.a_x; cy = r_item.a_y; cz = r_item.a_z;
                cidx = r_item.corner_index_a;
            end
            2'd1: begin
                cx = r_item.b_x; cy = r_item.b_y; cz = r_item.b_z;
                cidx = r_item.corner_index_b;
            end
            2'd2: begin
                cx = r_item.c_x; cy = r_item.c_y; cz = r_item.c_z;
                cidx = r_item.corner_index_c;
            end
            default: begin
                cx = '0; cy = '0; cz = '0;
                cidx = '0;
            end
        endcase
    end

    trc_bound_chk u_chk (
        .i_clk  (i_clk),
        .i_rect (r_rect),
        .i_x    (cx),
        .i_z    (cz),
        .o_pass (pass)
    );

    // Configuration decode; a known register also clears the table.
    always_comb begin
        cfg_wr  = i_cfg.valid && i_cfg.ready;
        cfg_hit = 1'b0;
        n_rect  = r_rect;
        if (cfg_wr) begin
            unique case (i_cfg.data.index)
                REG_MIN_X: begin n_rect.min_x = i_cfg.data.value; cfg_hit = 1'b1; end
                REG_MAX_X: begin n_rect.max_x = i_cfg.data.value; cfg_hit = 1'b1; end
                REG_MIN_Z: begin n_rect.min_z = i_cfg.data.value; cfg_hit = 1'b1; end
                REG_MAX_Z: begin n_rect.max_z = i_cfg.data.value; cfg_hit = 1'b1; end
                default: begin
                    cfg_hit = 1'b0;
                end
            endcase
        end
    end

    always_comb begin
        rmp_req.start = (r_state == S_LOOK);
        rmp_req.clear = cfg_hit;
        rmp_req.index = cidx;
    end

    trc_remap u_remap (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (rmp_req),
        .o_rsp   (rmp_rsp)
    );

    // Sequencer: check the three corners, then remap and emit each one.
    always_comb begin
        n_state     = r_state;
        n_k         = r_k;
        n_item      = r_item;
        n_pend      = r_pend;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        if (r_out_valid && o_res.ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (i_tri.valid) begin
                    n_item  = i_tri.data;
                    n_k     = 2'd0;
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                n_state = S_CHKW;
            end
            S_CHKW: begin
                if (!pass) begin
                    n_state = S_IDLE;
                end else if (r_k == 2'd2) begin
                    n_k     = 2'd0;
                    n_state = S_LOOK;
                end else begin
                    n_k     = r_k + 2'd1;
                    n_state = S_CHK;
                end
            end
            S_LOOK: begin
                n_state = S_LWAIT;
            end
            S_LWAIT: begin
                if (rmp_rsp.done) begin
                    n_pend.compact_index = rmp_rsp.number;
                    n_pend.vertex_is_new = rmp_rsp.is_new;
                    n_pend.out_x         = rmp_rsp.is_new ? cx : '0;
                    n_pend.out_y         = rmp_rsp.is_new ? cy : '0;
                    n_pend.out_z         = rmp_rsp.is_new ? cz : '0;
                    n_pend.last_corner   = (r_k == 2'd2);
                    n_state              = S_EMIT;
                end
            end
            S_EMIT: begin
                if (!r_out_valid || o_res.ready) begin
                    n_out       = r_pend;
                    n_out_valid = 1'b1;
                    if (r_k == 2'd2) begin
                        n_state = S_IDLE;
                    end else begin
                        n_k     = r_k + 2'd1;
                        n_state = S_LOOK;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State, control and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_k         <= 2'd0;
            r_out_valid <= 1'b0;
            r_rect      <= '0;
        end else begin
            r_state     <= n_state;
            r_k         <= n_k;
            r_out_valid <= n_out_valid;
            r_rect      <= n_rect;
        end
        r_item <= n_item;
        r_pend <= n_pend;
        r_out  <= n_out;
    end

    assign i_tri.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;

    // A repeated vertex carries zero coordinates.
    a_old_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && !o_res.data.vertex_is_new
        |-> (o_res.data.out_x == '0) && (o_res.data.out_y == '0) &&
            (o_res.data.out_z == '0))
        else $error("repeated vertex with nonzero coordinates");

    // A remap response seen in the wait state is always taken into the emit step.
    a_lwait_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LWAIT) && rmp_rsp.done |=> (r_state == S_EMIT))
        else $error("remap response not taken");

    // No triangle is accepted while a lookup is in flight.
    a_accept_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_tri.valid && i_tri.ready |-> !rmp_rsp.done)
        else $error("triangle accepted during a remap lookup");

endmodule

/* hdl/trc_bound_chk.sv */
// ----------------------------------------------------------------------------
// trc_bound_chk
// Shared bound compare unit: tests one corner per cycle against the keep
// rectangle, inclusive on all four bounds, and registers the verdict.
// ----------------------------------------------------------------------------
module trc_bound_chk import trc_pkg::*; (
    input  logic   i_clk,
    input  t_rect  i_rect,
    input  t_coord i_x,
    input  t_coord i_z,
    output logic   o_pass
);

    logic r_pass;
    logic n_pass;

    // Four signed compares, all inclusive.
    always_comb begin
        n_pass = (i_x >= i_rect.min_x) && (i_x <= i_rect.max_x) &&
                 (i_z >= i_rect.min_z) && (i_z <= i_rect.max_z);
    end

    always_ff @(posedge i_clk) begin
        r_pass <= n_pass;
    end

    assign o_pass = r_pass;

endmodule

/* hdl/trc_remap.sv */
// ----------------------------------------------------------------------------
// trc_remap
// Index remap unit. A sparse memory maps an original slot to a compact
// number, and a dense memory maps each handed-out number back to its slot.
// An entry counts as present when its number is below the fill count and the
// dense entry points back at the slot, so clearing is just zeroing the count.
// ----------------------------------------------------------------------------
module trc_remap import trc_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_rmp_req i_req,
    output t_rmp_rsp o_rsp
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SP,
        S_DN
    } t_state;

    logic [NUM_W-1:0] sparse_mem [VERTEX_SPACE];
    logic [IDX_W-1:0] dense_mem  [DENSE_DEPTH];

    t_state           r_state;
    t_state           n_state;
    logic [IDX_W-1:0] r_idx;
    logic [IDX_W-1:0] n_idx;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic [NUM_W-1:0] r_s_q;
    logic [IDX_W-1:0] r_d_q;

    logic             hit;
    logic [IDX_W-1:0] s_addr;
    logic             s_re;
    logic             s_we;
    logic [NUM_W-1:0] d_addr;
    logic             d_re;
    logic             d_we;

    // Present only if the number is live and the back pointer agrees.
    always_comb begin
        hit = 1'b0;
        if (({1'b0, r_s_q} < r_count) && (r_d_q == r_idx)) begin
            hit = 1'b1;
        end
    end

    // Memory port control.
    always_comb begin
        s_addr = (r_state == S_IDLE) ? i_req.index[IDX_W-1:0] : r_idx;
        s_re   = (r_state == S_IDLE) && i_req.start;
        s_we   = (r_state == S_DN) && !hit;
        d_addr = (r_state == S_SP) ? r_s_q : r_count[NUM_W-1:0];
        d_re   = (r_state == S_SP);
        d_we   = (r_state == S_DN) && !hit;
    end

    // Sequencer: sparse read, dense read, then decide and insert.
    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_count = r_count;
        unique case (r_state)
            S_IDLE: begin
                if (i_req.start) begin
                    n_idx   = i_req.index[IDX_W-1:0];
                    n_state = S_SP;
                end
            end
            S_SP: begin
                n_state = S_DN;
            end
            S_DN: begin
                if (!hit && (r_count < CNT_MAX)) begin
                    n_count = r_count + CNT_W'(1);
                end
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (i_req.clear) begin
            n_count = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
        r_idx <= n_idx;
    end

    // Sparse memory, single port.
    always_ff @(posedge i_clk) begin
        if (s_we) begin
            sparse_mem[s_addr] <= r_count[NUM_W-1:0];
        end
        if (s_re) begin
            r_s_q <= sparse_mem[s_addr];
        end
    end

    // Dense memory, single port.
    always_ff @(posedge i_clk) begin
        if (d_we) begin
            dense_mem[d_addr] <= r_idx;
        end
        if (d_re) begin
            r_d_q <= dense_mem[d_addr];
        end
    end

    always_comb begin
        o_rsp.done   = (r_state == S_DN);
        o_rsp.is_new = !hit;
        o_rsp.number = hit ? r_s_q : r_count[NUM_W-1:0];
    end

    // The fill count never passes the number of distinct compact numbers.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_MAX)
        else $error("remap fill count out of range");

    // A clear empties the table on the next cycle.
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.clear |=> (r_count == '0))
        else $error("remap clear did not reset the fill count");

    // An insert advances the fill count by one.
    a_insert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DN) && !hit && (r_count < CNT_MAX) && !i_req.clear
        |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("remap insert did not advance the fill count");

endmodule
